// File: rtl/utf8dmc_pkg.sv
// Shared definitions for the UTF-8 decoder and mark classifier.
// Holds the result status codes, smallest legal values and the mark test.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package utf8dmc_pkg;

   localparam int CpWidth = 21;

   typedef logic [CpWidth-1:0] cp_type;
   typedef logic [2:0]         status_type;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_BAD_LEAD = 3'd1;
   localparam status_type ST_BAD_CONT = 3'd2;
   localparam status_type ST_OVERLONG = 3'd3;
   localparam status_type ST_TRUNC    = 3'd4;

   // Smallest legal value for each sequence length.
   localparam cp_type MIN_TWO   = 21'h00080;
   localparam cp_type MIN_THREE = 21'h00800;
   localparam cp_type MIN_FOUR  = 21'h10000;

   localparam cp_type COMB_LOW  = 21'h00300;
   localparam cp_type COMB_HIGH = 21'h0036F;

   function automatic logic mark_test(input cp_type cp);
      logic hit;
      begin
         case (cp)
            21'h00020, 21'h00009, 21'h0000D, 21'h0000A,
            21'h0002F, 21'h0005B, 21'h0005D, 21'h00028, 21'h00029,
            21'h0007B, 21'h0007D, 21'h0002E, 21'h0002D, 21'h0007C,
            21'h002C8, 21'h002CC, 21'h002D0, 21'h002D1, 21'h02016: hit = 1'b1;
            default: hit = (cp >= COMB_LOW) && (cp <= COMB_HIGH);
         endcase
         return hit;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_decoder_mark_classifier.sv
// Top level of the UTF-8 decoder with transcription mark classifier.
// Depends on utf8dmc_pkg for status codes, value limits and the mark test.
//
//   channel | dir | tdata                                    | tuser      | tlast
//   req     | in  | [7:0] text_byte                          | -          | end_of_text
//   rsp     | out | [20:0] code_point, [23:21] byte_count,   | [2:0]      | last_result
//           |     | [24] is_mark, [31:25] zero               | status     |
//
// One byte is taken every cycle while no stalled result holds back the input register.
// The byte goes to an input register, is decoded against the sequence state
// in one pass and the result is written to the output register.
// Reset is synchronous and clears the sequence state and both valid flags.
// A stalled result register holds its transfer and holds back the input register.
`default_nettype none

module utf8_decoder_mark_classifier
   import utf8dmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [20:0] code_point, [23:21] byte_count,
                                         // [24] is_mark, [31:25] zero
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic             rsp_tlast
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Sequence state.
   logic [1:0] remain_ff, remain_in;
   cp_type     acc_ff, acc_in;
   logic [2:0] seq_len_ff, seq_len_in;
   logic       rejected_ff, rejected_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   cp_type     rsp_cp_ff;
   logic [2:0] rsp_count_ff;
   logic       rsp_mark_ff;
   status_type rsp_status_ff;
   logic       rsp_last_ff;

   logic       out_free;
   logic       take;
   logic       emit;
   logic       fail;
   status_type err_code;
   cp_type     ok_cp;
   logic [2:0] ok_count;
   cp_type     acc_shift;
   logic [1:0] remain_dec;
   logic       lead_two, lead_three, lead_four;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign take       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign lead_two   = (in_byte_ff[7:5] == 3'b110);
   assign lead_three = (in_byte_ff[7:4] == 4'b1110);
   assign lead_four  = (in_byte_ff[7:3] == 5'b11110);
   assign acc_shift  = {acc_ff[CpWidth-7:0], in_byte_ff[5:0]};
   assign remain_dec = remain_ff - 2'd1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      remain_in   = remain_ff;
      acc_in      = acc_ff;
      seq_len_in  = seq_len_ff;
      rejected_in = rejected_ff;
      emit        = 1'b0;
      fail        = 1'b0;
      err_code    = ST_OK;
      ok_cp       = '0;
      ok_count    = '0;
      if (take) begin
         if (rejected_ff) begin
            // Drop everything up to and including the end of the text.
            if (in_last_ff) begin
               rejected_in = 1'b0;
               remain_in   = '0;
               acc_in      = '0;
               seq_len_in  = '0;
            end
         end else if (remain_ff == 2'd0) begin
            if (!in_byte_ff[7]) begin
               emit     = 1'b1;
               ok_cp    = {{(CpWidth-8){1'b0}}, in_byte_ff};
               ok_count = 3'd1;
            end else if (!(lead_two || lead_three || lead_four)) begin
               fail     = 1'b1;
               err_code = ST_BAD_LEAD;
            end else if (in_last_ff) begin
               fail     = 1'b1;
               err_code = ST_TRUNC;
            end else if (lead_two) begin
               seq_len_in = 3'd2;
               remain_in  = 2'd1;
               acc_in     = {{(CpWidth-5){1'b0}}, in_byte_ff[4:0]};
            end else if (lead_three) begin
               seq_len_in = 3'd3;
               remain_in  = 2'd2;
               acc_in     = {{(CpWidth-4){1'b0}}, in_byte_ff[3:0]};
            end else begin
               seq_len_in = 3'd4;
               remain_in  = 2'd3;
               acc_in     = {{(CpWidth-3){1'b0}}, in_byte_ff[2:0]};
            end
         end else if (in_last_ff && (remain_ff > 2'd1)) begin
            fail     = 1'b1;
            err_code = ST_TRUNC;
         end else if (in_byte_ff[7:6] != 2'b10) begin
            fail     = 1'b1;
            err_code = ST_BAD_CONT;
         end else if (remain_dec != 2'd0) begin
            acc_in    = acc_shift;
            remain_in = remain_dec;
         end else if (((seq_len_ff == 3'd2) && (acc_shift < MIN_TWO)) ||
                      ((seq_len_ff == 3'd3) && (acc_shift < MIN_THREE)) ||
                      ((seq_len_ff == 3'd4) && (acc_shift < MIN_FOUR))) begin
            fail     = 1'b1;
            err_code = ST_OVERLONG;
         end else begin
            emit       = 1'b1;
            ok_cp      = acc_shift;
            ok_count   = seq_len_ff;
            remain_in  = '0;
            acc_in     = '0;
            seq_len_in = '0;
         end

         if (fail) begin
            emit        = 1'b1;
            remain_in   = '0;
            acc_in      = '0;
            seq_len_in  = '0;
            rejected_in = !in_last_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         remain_ff    <= '0;
         acc_ff       <= '0;
         seq_len_ff   <= '0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         remain_ff    <= remain_in;
         acc_ff       <= acc_in;
         seq_len_ff   <= seq_len_in;
         rejected_ff  <= rejected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (take && emit) begin
         rsp_cp_ff     <= ok_cp;
         rsp_count_ff  <= ok_count;
         rsp_mark_ff   <= !fail && mark_test(ok_cp);
         rsp_status_ff <= err_code;
         rsp_last_ff   <= in_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_mark_ff, rsp_count_ff, rsp_cp_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/utf8dmc_checker.sv
// Port-level checks for the UTF-8 decoder and mark classifier.
// Depends on utf8dmc_pkg; bound to the top level at the end of this file.
`default_nettype none

module utf8dmc_checker
   import utf8dmc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // No result can be pending in the cycle after a reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With the output side empty, the input side must take a transfer.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while no result is pending");

   // A stalled result holds its contents.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // Error results carry no code point, length or mark.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata == 32'd0))
      else $error("error result with nonzero data");

   // Good results have a length of one to four and a value that fits it.
   a_length_fits: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_OK)) |->
         (((rsp_tdata[23:21] == 3'd1) && (rsp_tdata[20:0] < MIN_TWO)) ||
          ((rsp_tdata[23:21] == 3'd2) && (rsp_tdata[20:0] >= MIN_TWO)
             && (rsp_tdata[20:0] < MIN_THREE)) ||
          ((rsp_tdata[23:21] == 3'd3) && (rsp_tdata[20:0] >= MIN_THREE)) ||
          ((rsp_tdata[23:21] == 3'd4) && (rsp_tdata[20:0] >= MIN_FOUR))))
      else $error("good result with bad length or value");

endmodule

bind utf8_decoder_mark_classifier utf8dmc_checker u_checker (.*);

`default_nettype wire
